>>> design/bmp_1bpp_stream_decoder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker of the BMP stream decoder.
// ----------------------------------------------------------------------------
`ifndef BMP_1BPP_STREAM_DECODER_MACROS_SVH
`define BMP_1BPP_STREAM_DECODER_MACROS_SVH

// Property sampled on the rising clock edge and ignored while reset is high.
`define BMPD_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bmp decoder property violated");

// Property sampled on the rising clock edge, reset included.
`define BMPD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bmp decoder property violated");

`endif

>>> design/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// bmpd_pkg
// Types and constants shared by the 1bpp BMP stream decoder modules.
// ----------------------------------------------------------------------------
package bmpd_pkg;

   // Verdict codes carried in the status field.
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_BEYOND    = 3'd2,
      ST_FORMAT    = 3'd3,
      ST_TRUNC     = 3'd4,
      ST_LARGE     = 3'd5,
      ST_IN_HEADER = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_JUDGE,
      PH_SKIP,
      PH_PIXELS,
      PH_IDLE,
      PH_REJECT
   } phase_type;

   localparam logic KIND_PIXEL   = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Header layout (byte positions within the file).
   localparam logic [4:0] OFFSET_LO = 5'd10;
   localparam logic [4:0] OFFSET_HI = 5'd13;
   localparam logic [4:0] WIDTH_LO  = 5'd18;
   localparam logic [4:0] WIDTH_HI  = 5'd21;
   localparam logic [4:0] HEIGHT_LO = 5'd22;
   localparam logic [4:0] HEIGHT_HI = 5'd25;
   localparam logic [4:0] DEPTH_LO  = 5'd28;
   localparam logic [4:0] HDR_LAST  = 5'd29;
   localparam logic [31:0] HDR_LEN  = 32'd30;
   localparam logic [15:0] DEPTH_MONO = 16'd1;

   localparam int RSP_DATA_W = 32;

   // One pending piece of work for the result emitter.
   typedef struct packed {
      logic       kind;
      status_type status;
      logic [7:0] data_byte;
      logic [11:0] xbase;
      logic [11:0] pos_y;
      logic [2:0] last_idx;
   } slot_type;

   typedef struct packed {
      logic       valid;
      status_type status;
      logic [29:0] row_bytes;
      logic       empty;
   } verdict_type;

endpackage

>>> design/bmpd_header.sv
// ----------------------------------------------------------------------------
// bmpd_header
// Captures the header fields and judges the header once the last header byte
// has arrived. The size product is built from four 16x16 partial products.
// ----------------------------------------------------------------------------
module bmpd_header #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  capture_en,
   input  logic [4:0]            pos,
   input  logic [7:0]            data_byte,
   input  logic                  judge_start,
   input  logic [31:0]           file_length,
   output logic [31:0]           pixel_start,
   output logic [31:0]           image_width,
   output logic [31:0]           image_height,
   output bmpd_pkg::verdict_type verdict
);

   logic [31:0] pixel_start_ff;
   logic [31:0] width_ff;
   logic [31:0] height_ff;
   logic [15:0] depth_ff;
   logic        busy_ff, busy_in;
   logic [2:0]  step_ff, step_in;
   logic [59:0] acc_ff, acc_in;

   logic [1:0]  lane;
   logic [29:0] req_bytes;
   logic [27:0] row_words;
   logic [29:0] row_bytes;
   logic [15:0] part_a;
   logic [15:0] part_b;
   logic [31:0] partial;
   logic [59:0] partial_ext;
   logic [59:0] partial_sh;
   logic [31:0] room;
   bmpd_pkg::status_type status;

   // The three four-byte fields all start at a position that is 2 mod 4.
   assign lane = pos[1:0] - 2'd2;

   always_ff @(posedge clock) begin
      if (capture_en) begin
         unique case (pos) inside
            [bmpd_pkg::OFFSET_LO:bmpd_pkg::OFFSET_HI]: begin
               pixel_start_ff[{lane, 3'b000} +: 8] <= data_byte;
            end
            [bmpd_pkg::WIDTH_LO:bmpd_pkg::WIDTH_HI]: begin
               width_ff[{lane, 3'b000} +: 8] <= data_byte;
            end
            [bmpd_pkg::HEIGHT_LO:bmpd_pkg::HEIGHT_HI]: begin
               height_ff[{lane, 3'b000} +: 8] <= data_byte;
            end
            [bmpd_pkg::DEPTH_LO:bmpd_pkg::HDR_LAST]: begin
               depth_ff[{pos[0], 3'b000} +: 8] <= data_byte;
            end
            default: begin
            end
         endcase
      end
   end

   // Row length in bytes: whole bytes per row, rounded up to whole words.
   always_comb begin
      req_bytes = {1'b0, width_ff[31:3]} + {29'd0, |width_ff[2:0]};
      row_words = req_bytes[29:2] + {27'd0, |req_bytes[1:0]};
      row_bytes = {row_words, 2'b00};
   end

   // Steps 0 to 3 accumulate one partial product each; step 4 gives the verdict.
   always_comb begin
      part_a = step_ff[1] ? {2'b00, row_bytes[29:16]} : row_bytes[15:0];
      part_b = step_ff[0] ? {1'b0, height_ff[30:16]} : height_ff[15:0];
      partial = {16'd0, part_a} * {16'd0, part_b};
      partial_ext = {28'd0, partial};
      case (step_ff[1:0])
         2'd0:    partial_sh = partial_ext;
         2'd3:    partial_sh = partial_ext << 32;
         default: partial_sh = partial_ext << 16;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      acc_in  = acc_ff;
      if (judge_start) begin
         busy_in = 1'b1;
         step_in = 3'd0;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (step_ff[2]) begin
            busy_in = 1'b0;
         end else begin
            acc_in  = acc_ff + partial_sh;
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Only meaningful once the offset is known to lie inside the file.
   assign room = file_length - pixel_start_ff;

   always_comb begin
      if (file_length < bmpd_pkg::HDR_LEN) begin
         status = bmpd_pkg::ST_SHORT;
      end else if (pixel_start_ff >= file_length) begin
         status = bmpd_pkg::ST_BEYOND;
      end else if (pixel_start_ff < bmpd_pkg::HDR_LEN) begin
         status = bmpd_pkg::ST_IN_HEADER;
      end else if (height_ff[31] || depth_ff != bmpd_pkg::DEPTH_MONO) begin
         status = bmpd_pkg::ST_FORMAT;
      end else if (acc_ff > {28'd0, room}) begin
         status = bmpd_pkg::ST_TRUNC;
      end else if (width_ff > 32'(MAX_WIDTH) || height_ff > 32'(MAX_HEIGHT)) begin
         status = bmpd_pkg::ST_LARGE;
      end else begin
         status = bmpd_pkg::ST_OK;
      end
   end

   assign verdict.valid     = busy_ff && step_ff[2];
   assign verdict.status    = status;
   assign verdict.row_bytes = row_bytes;
   assign verdict.empty     = (width_ff == 32'd0) || (height_ff == 32'd0);

   assign pixel_start  = pixel_start_ff;
   assign image_width  = width_ff;
   assign image_height = height_ff;

endmodule

>>> design/bmpd_emit.sv
// ----------------------------------------------------------------------------
// bmpd_emit
// Holds one pending byte of work and issues its results into the output register
// one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module bmpd_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   input  bmpd_pkg::slot_type    load,
   output logic                  slot_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status[2:0], pos_x[14:3], pos_y[26:15], pixel_value[27], zeros[31:28]
   output logic [bmpd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // kind[0]
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic               slot_valid_ff, slot_valid_in;
   bmpd_pkg::slot_type slot_ff, slot_in;
   logic [2:0]         idx_ff, idx_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [bmpd_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;
   logic               rsp_tuser_ff;
   logic               rsp_tlast_ff;

   logic        out_free;
   logic        advance;
   logic        at_last;
   logic [11:0] pos_x;
   logic        pixel;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign advance    = slot_valid_ff && out_free;
   assign at_last    = idx_ff == slot_ff.last_idx;
   assign slot_ready = !slot_valid_ff || (advance && at_last);

   assign pos_x = slot_ff.xbase + {9'd0, idx_ff};
   // Pixels leave the byte most significant bit first.
   assign pixel = slot_ff.data_byte[3'd7 - idx_ff];

   always_comb begin
      slot_valid_in = slot_valid_ff;
      slot_in       = slot_ff;
      idx_in        = idx_ff;
      if (load_valid) begin
         slot_valid_in = 1'b1;
         slot_in       = load;
         idx_in        = 3'd0;
      end else if (advance && at_last) begin
         slot_valid_in = 1'b0;
      end else if (advance) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (advance) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      idx_ff  <= idx_in;
      if (advance) begin
         rsp_tdata_ff <= {4'd0, pixel, slot_ff.pos_y, pos_x, slot_ff.status};
         rsp_tuser_ff <= slot_ff.kind;
         rsp_tlast_ff <= at_last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

>>> design/bmp_1bpp_stream_decoder.sv
// ----------------------------------------------------------------------------
// bmp_1bpp_stream_decoder
// Decodes a 1bpp BMP file streamed one byte per transaction into a header
// verdict followed by one result per pixel.
// ----------------------------------------------------------------------------
// Header bytes are taken one per cycle, padding bytes one per cycle while the result
// slot is free; neither gives results. After the last header byte the input is held
// off while the size product is built; the verdict then passes through the result slot
// into the output register. A taken pixel byte is loaded into the result slot, which
// issues up to eight results, one per cycle unless the output stalls, as the next byte waits.
// Reset is synchronous: phase, counters, file length and output valid clear.
module bmp_1bpp_stream_decoder #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // data_byte[7:0]
   input  logic [7:0]  req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], pos_x[14:3], pos_y[26:15], pixel_value[27], zeros[31:28]
   output logic [bmpd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // kind[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam int MAX_ROW_BYTES = ((MAX_WIDTH + 7) / 8 + 3) / 4 * 4;
   localparam int CB_W = $clog2(MAX_ROW_BYTES);
   localparam int RB_W = $clog2(MAX_ROW_BYTES + 1);
   localparam int WD_W = $clog2(MAX_WIDTH + 1);
   localparam int RC_W = $clog2(MAX_HEIGHT + 1);
   localparam int XW   = (WD_W > CB_W + 3) ? WD_W : CB_W + 3;

   bmpd_pkg::phase_type phase_ff, phase_in;
   logic [31:0]     file_length_ff;
   logic [31:0]     byte_pos_ff, byte_pos_in;
   logic [CB_W-1:0] column_ff, column_in;
   logic [RC_W-1:0] row_ff, row_in;
   logic [RB_W-1:0] row_bytes_ff, row_bytes_in;

   logic        accept;
   logic        capture_en;
   logic        judge_start;
   logic        pixel_go;
   logic        slot_ready;
   logic        load_valid;
   bmpd_pkg::slot_type    load;
   bmpd_pkg::verdict_type verdict;
   logic [31:0] pixel_start;
   logic [31:0] image_width;
   logic [31:0] image_height;

   logic [CB_W+2:0] base;
   logic [XW-1:0]   width_x;
   logic [XW-1:0]   base_x;
   logic [XW-1:0]   diff;
   logic            has_pix;
   logic [2:0]      last_idx;
   logic [CB_W:0]   column_next;
   logic [RC_W:0]   row_next;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_length_ff <= 32'd0;
      end else if (csr_valid) begin
         file_length_ff <= csr_data;
      end
   end

   always_comb begin
      unique case (phase_ff) inside
         bmpd_pkg::PH_JUDGE:                      req_tready = 1'b0;
         bmpd_pkg::PH_SKIP, bmpd_pkg::PH_PIXELS:  req_tready = slot_ready;
         default:                                 req_tready = 1'b1;
      endcase
   end

   assign accept      = req_tvalid && req_tready;
   assign capture_en  = accept && (phase_ff == bmpd_pkg::PH_HEADER);
   assign judge_start = capture_en && (byte_pos_ff[4:0] == bmpd_pkg::HDR_LAST);
   assign pixel_go    = accept && ((phase_ff == bmpd_pkg::PH_PIXELS) ||
                        (phase_ff == bmpd_pkg::PH_SKIP && byte_pos_ff >= pixel_start));

   bmpd_header #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_header (
      .clock        (clock),
      .reset        (reset),
      .capture_en   (capture_en),
      .pos          (byte_pos_ff[4:0]),
      .data_byte    (req_tdata),
      .judge_start  (judge_start),
      .file_length  (file_length_ff),
      .pixel_start  (pixel_start),
      .image_width  (image_width),
      .image_height (image_height),
      .verdict      (verdict)
   );

   // Pixels covered by this byte: those of its eight columns left of the width.
   always_comb begin
      base     = {column_ff, 3'b000};
      width_x  = XW'(image_width[WD_W-1:0]);
      base_x   = XW'(base);
      has_pix  = width_x > base_x;
      diff     = width_x - base_x;
      last_idx = (diff >= XW'(8)) ? 3'd7 : 3'(diff - XW'(1));
   end

   always_comb begin
      load_valid = verdict.valid || (pixel_go && has_pix);
      if (verdict.valid) begin
         load.kind      = bmpd_pkg::KIND_VERDICT;
         load.status    = verdict.status;
         load.data_byte = 8'd0;
         load.xbase     = 12'd0;
         load.pos_y     = 12'd0;
         load.last_idx  = 3'd0;
      end else begin
         load.kind      = bmpd_pkg::KIND_PIXEL;
         load.status    = bmpd_pkg::ST_OK;
         load.data_byte = req_tdata;
         load.xbase     = 12'(base);
         load.pos_y     = 12'(row_ff);
         load.last_idx  = last_idx;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      byte_pos_in  = byte_pos_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      row_bytes_in = row_bytes_ff;
      column_next  = {1'b0, column_ff} + {{CB_W{1'b0}}, 1'b1};
      row_next     = {1'b0, row_ff} + {{RC_W{1'b0}}, 1'b1};

      if (accept && byte_pos_ff != 32'hFFFF_FFFF) begin
         byte_pos_in = byte_pos_ff + 32'd1;
      end

      if (judge_start) begin
         phase_in = bmpd_pkg::PH_JUDGE;
      end

      if (verdict.valid) begin
         column_in    = '0;
         row_in       = '0;
         row_bytes_in = RB_W'(verdict.row_bytes);
         if (verdict.status != bmpd_pkg::ST_OK) begin
            phase_in = bmpd_pkg::PH_REJECT;
         end else if (verdict.empty) begin
            phase_in = bmpd_pkg::PH_IDLE;
         end else begin
            phase_in = bmpd_pkg::PH_SKIP;
         end
      end

      if (pixel_go) begin
         phase_in = bmpd_pkg::PH_PIXELS;
         if (column_next >= (CB_W+1)'(row_bytes_ff)) begin
            column_in = '0;
            row_in    = row_next[RC_W-1:0];
            if (row_next >= (RC_W+1)'(image_height[RC_W-1:0])) begin
               phase_in = bmpd_pkg::PH_IDLE;
            end
         end else begin
            column_in = column_next[CB_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= bmpd_pkg::PH_HEADER;
         byte_pos_ff  <= 32'd0;
         column_ff    <= '0;
         row_ff       <= '0;
         row_bytes_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         byte_pos_ff  <= byte_pos_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         row_bytes_ff <= row_bytes_in;
      end
   end

   bmpd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_valid (load_valid),
      .load       (load),
      .slot_ready (slot_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> design/bmpd_checker.sv
// ----------------------------------------------------------------------------
// bmpd_checker
// Port-level checks on the result stream of the BMP stream decoder.
// ----------------------------------------------------------------------------
`include "bmp_1bpp_stream_decoder_macros.svh"

module bmpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled transaction keeps its contents.
   `BMPD_ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // A verdict is a single transaction with no pixel payload.
   `BMPD_ASSERT_CLK(a_verdict_alone, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata[31:3] == 29'd0)

   // Pixel transactions always carry an ok status.
   `BMPD_ASSERT_CLK(a_pixel_status, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata[2:0] == 3'd0)

   `BMPD_ASSERT_ALWAYS(a_reset_clears, clock, $past(reset) |-> !rsp_tvalid)

endmodule

bind bmp_1bpp_stream_decoder bmpd_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

>>> tb/sv/tb_bmp_1bpp_stream_decoder.sv
// ----------------------------------------------------------------------------
// tb_bmp_1bpp_stream_decoder
// Streams one 1bpp bitmap file, header first, through the decoder and checks
// every verdict and pixel transaction against a behavioural decoder kept in
// step with the accepted bytes. The file shape is picked at random per run.
// ----------------------------------------------------------------------------
module tb_bmp_1bpp_stream_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIDTH_LIMIT  = 4096;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic                 kind;
      bmpd_pkg::status_type status;
      logic [11:0]          pos_x;
      logic [11:0]          pos_y;
      logic                 pixel_value;
      logic                 last;
   } decoded_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [bmpd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   bmp_1bpp_stream_decoder #(
      .MAX_WIDTH  (WIDTH_LIMIT),
      .MAX_HEIGHT (HEIGHT_LIMIT)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Decoder state mirrored from the accepted bytes.
   logic [31:0] file_len_q = '0;
   logic [31:0] byte_pos   = '0;
   logic [31:0] pix_offset = '0;
   logic [31:0] img_width  = '0;
   logic [31:0] img_height = '0;
   logic [15:0] depth_q    = '0;
   logic [31:0] col_byte   = '0;
   logic [31:0] row_idx    = '0;
   logic [31:0] row_span   = '0;
   bmpd_pkg::phase_type dec_phase = bmpd_pkg::PH_HEADER;

   logic [7:0]         file_bytes[$];
   decoded_result_type decoded_results[$];
   bit                 feeding = 1'b0;
   int                 planned_bytes = 1;
   int                 sent_bytes = 0;
   int                 error_count = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #30_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic bmpd_pkg::status_type judge_header();
      logic [63:0] need_bytes;
      logic [63:0] tail_pos;
      if (file_len_q < bmpd_pkg::HDR_LEN) return bmpd_pkg::ST_SHORT;
      if (pix_offset >= file_len_q) return bmpd_pkg::ST_BEYOND;
      if (pix_offset < bmpd_pkg::HDR_LEN) return bmpd_pkg::ST_IN_HEADER;
      if (img_height[31] || depth_q != bmpd_pkg::DEPTH_MONO) return bmpd_pkg::ST_FORMAT;
      need_bytes = (64'(img_width) + 64'd7) / 64'd8;
      row_span   = 32'(((need_bytes + 64'd3) / 64'd4) * 64'd4);
      tail_pos   = 64'(pix_offset) + 64'(row_span) * 64'(img_height);
      if (tail_pos > 64'(file_len_q)) return bmpd_pkg::ST_TRUNC;
      if (64'(img_width) > 64'(WIDTH_LIMIT) || 64'(img_height) > 64'(HEIGHT_LIMIT))
         return bmpd_pkg::ST_LARGE;
      return bmpd_pkg::ST_OK;
   endfunction

   // Advances the mirrored decoder by one file byte and queues what it yields.
   task automatic decode_byte(input logic [7:0] b);
      logic [31:0]          pos;
      logic [63:0]          xpos;
      bmpd_pkg::status_type verdict;
      decoded_result_type   item;
      int                   count;
      pos = byte_pos;
      if (byte_pos != '1) byte_pos++;
      if (dec_phase == bmpd_pkg::PH_HEADER) begin
         if (pos >= bmpd_pkg::OFFSET_LO && pos <= bmpd_pkg::OFFSET_HI) begin
            pix_offset[(pos - bmpd_pkg::OFFSET_LO) * 8 +: 8] = b;
         end else if (pos >= bmpd_pkg::WIDTH_LO && pos <= bmpd_pkg::WIDTH_HI) begin
            img_width[(pos - bmpd_pkg::WIDTH_LO) * 8 +: 8] = b;
         end else if (pos >= bmpd_pkg::HEIGHT_LO && pos <= bmpd_pkg::HEIGHT_HI) begin
            img_height[(pos - bmpd_pkg::HEIGHT_LO) * 8 +: 8] = b;
         end else if (pos >= bmpd_pkg::DEPTH_LO && pos <= bmpd_pkg::HDR_LAST) begin
            depth_q[(pos - bmpd_pkg::DEPTH_LO) * 8 +: 8] = b;
         end
         if (pos == bmpd_pkg::HDR_LAST) begin
            verdict = judge_header();
            decoded_results.push_back('{bmpd_pkg::KIND_VERDICT, verdict, 12'd0, 12'd0,
                                        1'b0, 1'b1});
            col_byte = '0;
            row_idx  = '0;
            if (verdict != bmpd_pkg::ST_OK) dec_phase = bmpd_pkg::PH_REJECT;
            else if (img_width == 0 || img_height == 0) dec_phase = bmpd_pkg::PH_IDLE;
            else dec_phase = bmpd_pkg::PH_SKIP;
         end
         return;
      end
      if (dec_phase == bmpd_pkg::PH_SKIP) begin
         if (pos < pix_offset) return;
         dec_phase = bmpd_pkg::PH_PIXELS;
      end
      if (dec_phase == bmpd_pkg::PH_PIXELS) begin
         count = 0;
         for (int i = 0; i < 8; i++) begin
            if (64'(col_byte) * 64'd8 + 64'(i) < 64'(img_width)) count++;
         end
         for (int i = 0; i < count; i++) begin
            xpos = 64'(col_byte) * 64'd8 + 64'(i);
            item = '{bmpd_pkg::KIND_PIXEL, bmpd_pkg::ST_OK, xpos[11:0], row_idx[11:0],
                     b[7 - i], i == count - 1};
            decoded_results.push_back(item);
         end
         col_byte++;
         if (col_byte >= row_span) begin
            col_byte = '0;
            row_idx++;
            if (row_idx >= img_height) dec_phase = bmpd_pkg::PH_IDLE;
         end
      end
   endtask

   function automatic bit roll(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // The run moves through four load phases as the file is consumed.
   function automatic int load_phase();
      int p;
      p = (sent_bytes * 4) / planned_bytes;
      return (p > 3) ? 3 : p;
   endfunction

   function automatic int sender_idle_pct();
      case (load_phase())
         1: return 86;
         3: return 7;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case (load_phase())
         2: return 86;
         3: return 7;
         default: return 0;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata);
            sent_bytes++;
         end
         if (req_tvalid && !req_tready) begin
            // Keep the transaction on the bus until it is taken.
         end else if (feeding && file_bytes.size() > 0 && !roll(sender_idle_pct())) begin
            req_tvalid <= 1'b1;
            req_tdata  <= file_bytes.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !roll(receiver_stall_pct());
      end
   end

   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) file_len_q <= csr_data;
   end

   always @(posedge clock) begin
      decoded_result_type seen;
      decoded_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = '{rsp_tuser, bmpd_pkg::status_type'(rsp_tdata[2:0]), rsp_tdata[14:3],
                  rsp_tdata[26:15], rsp_tdata[27], rsp_tlast};
         if (decoded_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result: kind %0d status %0d x %0d y %0d value %0d last %0d",
                        seen.kind, seen.status, seen.pos_x, seen.pos_y,
                        seen.pixel_value, seen.last);
         end else begin
            want = decoded_results.pop_front();
            if (seen.kind !== want.kind || seen.status !== want.status ||
                seen.pos_x !== want.pos_x || seen.pos_y !== want.pos_y ||
                seen.pixel_value !== want.pixel_value || seen.last !== want.last) begin
               error_count++;
               if (error_count <= 10)
                  $display({"mismatch: expected kind %0d status %0d x %0d y %0d value %0d ",
                            "last %0d, got kind %0d status %0d x %0d y %0d value %0d last %0d"},
                           want.kind, want.status, want.pos_x, want.pos_y,
                           want.pixel_value, want.last, seen.kind, seen.status,
                           seen.pos_x, seen.pos_y, seen.pixel_value, seen.last);
            end
         end
      end
   end

   task automatic write_file_length(input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (file_bytes.size() > 0 || req_tvalid || decoded_results.size() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [7:0]  hdr [0:29];
      logic [31:0] offset_v, width_v, height_v, flen_v, rowb_v;
      logic [15:0] depth_v;
      int          shape, pixel_bytes, trailing;
      bit          accepted;

      do @(negedge clock); while (reset);

      shape    = $urandom_range(0, 19);
      offset_v = 32'd30 + $urandom_range(0, 12);
      depth_v  = 16'd1;
      width_v  = $urandom_range(1, 40);
      if (shape == 0) width_v = WIDTH_LIMIT;
      if (shape == 1) width_v = 1;
      rowb_v   = ((width_v + 7) / 8 + 3) / 4 * 4;
      height_v = (rowb_v >= 110) ? 1 : 110 / rowb_v - $urandom_range(0, 3);
      pixel_bytes = rowb_v * height_v;
      trailing = $urandom_range(0, 6);
      flen_v   = offset_v + pixel_bytes + trailing;
      accepted = 1'b0;
      case (shape)
         12: begin
            // Empty image: accepted, but no pixel transactions follow.
            if ($urandom_range(0, 1)) width_v = 0;
            else height_v = 0;
         end
         13: flen_v = $urandom_range(0, 29);
         14: begin
            if ($urandom_range(0, 1)) offset_v = 32'hFFFF_FFFF;
            flen_v = $urandom_range(30, 200);
            if (flen_v > offset_v) flen_v = offset_v;
         end
         15: offset_v = $urandom_range(0, 29);
         16: begin
            if ($urandom_range(0, 1)) height_v = -height_v;
            else depth_v = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(2, 65535));
         end
         17: begin
            if ($urandom_range(0, 1)) begin
               height_v = 32'h7FFF_FFFF;
               flen_v   = 32'hFFFF_FFFF;
            end else begin
               flen_v = offset_v + pixel_bytes - $urandom_range(1, pixel_bytes - 1);
            end
         end
         18: begin
            flen_v = 32'hFFFF_FFFF;
            if ($urandom_range(0, 1)) begin
               width_v  = $urandom_range(WIDTH_LIMIT + 1, 5000);
               height_v = 1;
            end else begin
               width_v  = 8;
               height_v = $urandom_range(HEIGHT_LIMIT + 1, 6000);
            end
         end
         default: accepted = 1'b1;
      endcase

      foreach (hdr[k]) hdr[k] = $urandom_range(0, 255);
      for (int k = 0; k < 4; k++) begin
         hdr[bmpd_pkg::OFFSET_LO + k] = offset_v[k * 8 +: 8];
         hdr[bmpd_pkg::WIDTH_LO + k]  = width_v[k * 8 +: 8];
         hdr[bmpd_pkg::HEIGHT_LO + k] = height_v[k * 8 +: 8];
      end
      hdr[bmpd_pkg::DEPTH_LO] = depth_v[7:0];
      hdr[bmpd_pkg::HDR_LAST] = depth_v[15:8];
      foreach (hdr[k]) file_bytes.push_back(hdr[k]);

      if (accepted) begin
         for (int k = 30; k < offset_v; k++) file_bytes.push_back($urandom_range(0, 255));
         // Pixel data opens with the all-clear, all-set and single-bit patterns.
         file_bytes.push_back(8'h00);
         file_bytes.push_back(8'hFF);
         file_bytes.push_back(8'h80);
         file_bytes.push_back(8'h01);
         for (int k = 4; k < pixel_bytes + trailing; k++)
            file_bytes.push_back($urandom_range(0, 255));
      end else begin
         // Bytes after a rejected or empty header must be swallowed silently.
         repeat ($urandom_range(100, 120)) file_bytes.push_back($urandom_range(0, 255));
      end

      write_file_length(32'hFFFF_FFFF);
      write_file_length(32'h0000_0000);
      write_file_length(flen_v);
      planned_bytes = file_bytes.size();
      feeding = 1'b1;
      wait_drained();

      // With the file done the decoder ignores everything, including the register.
      write_file_length(32'h0000_0000);
      write_file_length(32'hFFFF_FFFF);
      repeat (8) file_bytes.push_back($urandom_range(0, 255));
      wait_drained();

      error_count += decoded_results.size();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
